[src/nrum_pkg.sv]
// Shared constants, types and reset values for the NFC response UID matcher.
package nrum_pkg;

	localparam int BYTE_W         = 8;
	localparam int UID_W          = 32;
	localparam int NUM_CARDS      = 3;
	localparam int HIST_BYTES     = 3;
	localparam int WAKE_FRAME_LEN = 15;
	localparam int CARD_FRAME_LEN = 25;
	localparam int MAX_FRAME_LEN  = (WAKE_FRAME_LEN > CARD_FRAME_LEN) ?
		WAKE_FRAME_LEN : CARD_FRAME_LEN;
	localparam int POS_W          = $clog2(MAX_FRAME_LEN + 1);
	localparam int CFG_IDX_W      = 2;
	localparam int CARD_IDX_W     = 2;

	// Wake frame check points and expected bytes
	localparam logic [POS_W-1:0]  WAKE_POS_A = POS_W'(4);
	localparam logic [POS_W-1:0]  WAKE_POS_B = POS_W'(11);
	localparam logic [POS_W-1:0]  WAKE_POS_C = POS_W'(12);
	localparam logic [BYTE_W-1:0] WAKE_VAL_A = 8'hFF;
	localparam logic [BYTE_W-1:0] WAKE_VAL_B = 8'hD5;
	localparam logic [BYTE_W-1:0] WAKE_VAL_C = 8'h15;

	localparam logic [POS_W-1:0] WAKE_LAST = POS_W'(WAKE_FRAME_LEN - 1);
	localparam logic [POS_W-1:0] CARD_LAST = POS_W'(CARD_FRAME_LEN - 1);
	localparam logic [POS_W-1:0] WIN_FULL  = POS_W'(HIST_BYTES);

	// Frame kind codes
	localparam logic FRAME_WAKE = 1'b0;
	localparam logic FRAME_CARD = 1'b1;

	localparam logic [CARD_IDX_W-1:0] CARD_NONE = '0;

	typedef logic [UID_W-1:0] uid_t;

	localparam uid_t CARD_UID_RESET [NUM_CARDS] = '{
		32'h04631F49, 32'h5084FC23, 32'h40748023
	};

	// Control to the byte history cells
	typedef struct packed {
		logic shift;
		logic clear;
	} hist_ctrl_t;

	// Control to the card match cells
	typedef struct packed {
		logic step;
		logic cmp_en;
		logic clear;
	} card_ctrl_t;

endpackage

[src/nrum_byte_cell.sv]
// One byte of the receive history; shifts toward older bytes on each card-phase beat.
module nrum_byte_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nrum_pkg::hist_ctrl_t        ctrl,
	input  logic [nrum_pkg::BYTE_W-1:0] din,
	output logic [nrum_pkg::BYTE_W-1:0] dout
);
	import nrum_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	// Clear at frame end, otherwise take the neighbor's byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

endmodule

[src/nrum_card_cell.sv]
// One preset card: window compare, sticky seen flag and a link in the priority chain.
module nrum_card_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nrum_pkg::card_ctrl_t       ctrl,
	input  logic [nrum_pkg::UID_W-1:0] window,
	input  logic [nrum_pkg::UID_W-1:0] uid,
	input  logic                       claim_in,
	output logic                       claim_out,
	output logic                       pick
);
	import nrum_pkg::*;

	logic seen_q;
	logic hit;
	logic seen_now;

	// Compare the window and fold into the frame's seen flag
	assign hit       = ctrl.cmp_en & (window == uid);
	assign seen_now  = seen_q | hit;
	// A lower-numbered card already claimed the frame
	assign pick      = seen_now & ~claim_in;
	assign claim_out = claim_in | seen_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctrl.step) begin
			seen_q <= ctrl.clear ? 1'b0 : seen_now;
		end
	end

endmodule

[src/nfc_response_uid_matcher.sv]
// Top level of the NFC response UID matcher: frame control, cell chains, result register.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, rx_byte               | one received byte
//  out     | out_valid, out_ready, frame_kind, wake_ok,| one frame result
//          | card_index, matched_uid                   |
//  cfg     | cfg_we, cfg_index, cfg_data               | one UID register write
//
// One byte per cycle while in_ready is high; the last byte of a frame loads the result register.
// Byte history and card compares are a row of cells, each updated once per accepted card-phase byte.
// Reset puts the block in the wake phase with the preset UIDs loaded.
// A held result stalls input only on a frame's last byte; other bytes keep flowing.
module nfc_response_uid_matcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nrum_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            frame_kind,
	output logic                            wake_ok,
	output logic [nrum_pkg::CARD_IDX_W-1:0] card_index,
	output logic [nrum_pkg::UID_W-1:0]      matched_uid,
	input  logic                            cfg_we,
	input  logic [nrum_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nrum_pkg::UID_W-1:0]      cfg_data
);
	import nrum_pkg::*;

	logic              awake_q;
	logic [POS_W-1:0]  pos_q;
	logic              pass_q;
	uid_t              uid_q [NUM_CARDS];

	logic              out_valid_q;
	logic              frame_kind_q;
	logic              wake_ok_q;
	logic [CARD_IDX_W-1:0] card_index_q;
	uid_t              matched_uid_q;

	logic              in_fire;
	logic              frame_last;
	logic              wake_fail;
	logic              wake_ok_now;
	hist_ctrl_t        hist_ctrl;
	card_ctrl_t        card_ctrl;
	logic [BYTE_W-1:0] hist [HIST_BYTES];
	uid_t              window;
	logic [NUM_CARDS:0] claim;
	logic [NUM_CARDS-1:0] pick;
	logic [CARD_IDX_W-1:0] idx_now;
	uid_t              uid_now;

	// Frame position and handshake
	assign frame_last = awake_q ? (pos_q == CARD_LAST) : (pos_q == WAKE_LAST);
	assign in_ready   = ~out_valid_q | out_ready | ~frame_last;
	assign in_fire    = in_valid & in_ready;

	// Wake frame byte checks
	assign wake_fail = ((pos_q == WAKE_POS_A) && (rx_byte != WAKE_VAL_A)) ||
	                   ((pos_q == WAKE_POS_B) && (rx_byte != WAKE_VAL_B)) ||
	                   ((pos_q == WAKE_POS_C) && (rx_byte != WAKE_VAL_C));
	assign wake_ok_now = pass_q & ~wake_fail;

	// Cell controls
	assign hist_ctrl.shift  = in_fire & awake_q;
	assign hist_ctrl.clear  = in_fire & frame_last;
	assign card_ctrl.step   = in_fire & awake_q;
	assign card_ctrl.cmp_en = (pos_q >= WIN_FULL);
	assign card_ctrl.clear  = frame_last;

	// Byte history chain
	for (genvar i = 0; i < HIST_BYTES; i++) begin : g_hist
		if (i == 0) begin : g_head
			nrum_byte_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (hist_ctrl),
				.din    (rx_byte),
				.dout   (hist[i])
			);
		end else begin : g_tail
			nrum_byte_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (hist_ctrl),
				.din    (hist[i-1]),
				.dout   (hist[i])
			);
		end
	end

	// Window: oldest history byte on top, current byte at the bottom
	always_comb begin
		window[BYTE_W-1:0] = rx_byte;
		for (int i = 0; i < HIST_BYTES; i++) begin
			window[BYTE_W*(i+1) +: BYTE_W] = hist[i];
		end
	end

	// Card compare chain; card 1 sits at the head and wins ties
	assign claim[0] = 1'b0;
	for (genvar k = 0; k < NUM_CARDS; k++) begin : g_card
		nrum_card_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (card_ctrl),
			.window    (window),
			.uid       (uid_q[k]),
			.claim_in  (claim[k]),
			.claim_out (claim[k+1]),
			.pick      (pick[k])
		);
	end

	// Encode the picked card and select its UID
	always_comb begin
		idx_now = CARD_NONE;
		uid_now = '0;
		for (int k = 0; k < NUM_CARDS; k++) begin
			if (pick[k]) begin
				idx_now = CARD_IDX_W'(k + 1);
				uid_now = uid_q[k];
			end
		end
	end

	// UID registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CARDS; k++) begin
				uid_q[k] <= CARD_UID_RESET[k];
			end
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_CARDS; k++) begin
				if (cfg_index == CFG_IDX_W'(k)) begin
					uid_q[k] <= cfg_data;
				end
			end
		end
	end

	// Phase, position and wake check state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awake_q <= 1'b0;
			pos_q   <= '0;
			pass_q  <= 1'b1;
		end else if (in_fire) begin
			if (frame_last) begin
				pos_q  <= '0;
				pass_q <= 1'b1;
				if (!awake_q) begin
					awake_q <= wake_ok_now;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (!awake_q) begin
					pass_q <= wake_ok_now;
				end
			end
		end
	end

	// Result register: load on a frame's last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && frame_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && frame_last) begin
			if (awake_q) begin
				frame_kind_q  <= FRAME_CARD;
				wake_ok_q     <= 1'b0;
				card_index_q  <= idx_now;
				matched_uid_q <= uid_now;
			end else begin
				frame_kind_q  <= FRAME_WAKE;
				wake_ok_q     <= wake_ok_now;
				card_index_q  <= CARD_NONE;
				matched_uid_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_kind  = frame_kind_q;
	assign wake_ok     = wake_ok_q;
	assign card_index  = card_index_q;
	assign matched_uid = matched_uid_q;

endmodule

[src/nrum_checker.sv]
// Port-level checks for the NFC response UID matcher, bound to the top level.
module nrum_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            frame_kind,
	input  logic                            wake_ok,
	input  logic [nrum_pkg::CARD_IDX_W-1:0] card_index,
	input  logic [nrum_pkg::UID_W-1:0]      matched_uid
);
	import nrum_pkg::*;

	// Hold a result beat until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// A fresh result follows an accepted byte
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted byte");

	// Wake results carry no card
	a_wake_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_kind == FRAME_WAKE) |->
		(card_index == CARD_NONE) && (matched_uid == '0))
		else $error("wake result carries card data");

	// Card results never flag a wake pass, and no card means zero UID
	a_card_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_kind == FRAME_CARD) |->
		!wake_ok && ((card_index != CARD_NONE) || (matched_uid == '0)))
		else $error("card result fields inconsistent");

endmodule

bind nfc_response_uid_matcher nrum_checker u_nrum_checker (.*);
